// ----- hdl/lgre_pkg.sv -----
package lgre_pkg;

   localparam int DataBits    = 64;
   localparam int RowNumBits  = 12;
   localparam int WidthBits   = 7;
   localparam int RspDataBits = 80;

   localparam logic [WidthBits-1:0] WidthReset = 7'd45;

   // B3/S23: a cell is born with three live neighbors and survives with two or three.
   localparam logic [3:0] BirthCount   = 4'd3;
   localparam logic [3:0] SurviveCount = 4'd2;

   typedef struct packed {
      logic load;     // an input row is transferred this cycle
      logic first;    // that row opens a new grid
      logic clear;    // the bottom row's own result leaves; the grid ends
      logic use_row;  // the row below the middle row is the input row, not dead
   } cell_ctl_type;

endpackage

// ----- hdl/life_generation_row_engine.sv -----
// Results: a row's next generation appears on rsp in the cycle after the transfer of the row
// below it; the bottom row's own result follows from the flush state once rsp can take it.
// Throughput: one row per cycle while rsp is not stalled, set by the single column-cell
// window; a row marked tlast holds req_tready low while its second result is produced.
// Reset: synchronous, active high; clears the cells, the row counter and the output
// valid flag, and sets grid_width to 45.
module life_generation_row_engine #(
   parameter int MAX_COLUMNS = 64,
   parameter int MAX_ROWS    = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [lgre_pkg::DataBits-1:0]     req_tdata,  // row_cells
   input  logic                              req_tlast,  // final_row_in
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [lgre_pkg::RspDataBits-1:0]  rsp_tdata,  // next_row_cells, row_number
   output logic                              rsp_tuser,  // grid_done
   output logic                              rsp_tlast,  // last
   input  logic                              csr_wr_en,
   input  logic [lgre_pkg::WidthBits-1:0]    csr_wr_data // grid_width
);

   localparam int RowBits = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [RowBits-1:0] RowLast = RowBits'(MAX_ROWS - 1);

   logic [lgre_pkg::WidthBits-1:0]   grid_width_ff, grid_width_in;
   logic                             in_grid_ff, in_grid_in;
   logic                             flush_ff, flush_in;
   logic [RowBits-1:0]               row_idx_ff, row_idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [lgre_pkg::DataBits-1:0]    rsp_cells_ff, rsp_cells_in;
   logic [lgre_pkg::RowNumBits-1:0]  rsp_row_ff, rsp_row_in;
   logic                             rsp_done_ff, rsp_done_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                    can_load, accept, fire_flush, emit;
   lgre_pkg::cell_ctl_type  ctl;
   logic [MAX_COLUMNS-1:0]  col_en, row_m, above_v, middle_v, next_v;
   logic [MAX_COLUMNS+1:0]  row_pad, above_pad, middle_pad;

   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = can_load && !flush_ff;
   assign accept     = req_tvalid && req_tready;
   assign fire_flush = flush_ff && can_load;
   assign emit       = (accept && in_grid_ff) || fire_flush;

   always_comb begin
      ctl.load    = accept;
      ctl.first   = !in_grid_ff;
      ctl.clear   = fire_flush;
      ctl.use_row = !flush_ff;
   end

   // Stored rows are masked again so that a narrowed width hides columns kept from before.
   assign row_m      = req_tdata[MAX_COLUMNS-1:0] & col_en;
   assign row_pad    = {1'b0, row_m, 1'b0};
   assign above_pad  = {1'b0, above_v & col_en, 1'b0};
   assign middle_pad = {1'b0, middle_v & col_en, 1'b0};

   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_col
      assign col_en[i] = (lgre_pkg::WidthBits'(i) < grid_width_ff);

      lgre_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .col_en     (col_en[i]),
         .row_bit    (row_m[i]),
         .row_lo     (row_pad[i]),
         .row_hi     (row_pad[i+2]),
         .above_lo   (above_pad[i]),
         .above_hi   (above_pad[i+2]),
         .middle_lo  (middle_pad[i]),
         .middle_hi  (middle_pad[i+2]),
         .above_bit  (above_v[i]),
         .middle_bit (middle_v[i]),
         .next_bit   (next_v[i])
      );
   end

   always_comb begin
      grid_width_in = csr_wr_en ? csr_wr_data : grid_width_ff;
      in_grid_in    = in_grid_ff;
      flush_in      = flush_ff;
      row_idx_in    = row_idx_ff;
      if (fire_flush) begin
         in_grid_in = 1'b0;
         flush_in   = 1'b0;
         row_idx_in = '0;
      end else if (accept) begin
         in_grid_in = 1'b1;
         flush_in   = req_tlast;
         if (!in_grid_ff) begin
            row_idx_in = '0;
         end else begin
            row_idx_in = (row_idx_ff == RowLast) ? '0 : row_idx_ff + 1'b1;
         end
      end
   end

   // The row index names the middle row, which is the row every result describes.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cells_in = rsp_cells_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_done_in  = rsp_done_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_cells_in = lgre_pkg::DataBits'(next_v);
         rsp_row_in   = lgre_pkg::RowNumBits'(row_idx_ff);
         rsp_done_in  = fire_flush;
         rsp_last_in  = fire_flush || !req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff <= lgre_pkg::WidthReset;
         in_grid_ff    <= 1'b0;
         flush_ff      <= 1'b0;
         row_idx_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         grid_width_ff <= grid_width_in;
         in_grid_ff    <= in_grid_in;
         flush_ff      <= flush_in;
         row_idx_ff    <= row_idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_cells_ff <= rsp_cells_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_done_ff  <= rsp_done_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_row_ff, rsp_cells_ff};
   assign rsp_tuser  = rsp_done_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hdl/lgre_cell.sv -----
module lgre_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lgre_pkg::cell_ctl_type ctl,
   input  logic                  col_en,
   input  logic                  row_bit,
   input  logic                  row_lo,
   input  logic                  row_hi,
   input  logic                  above_lo,
   input  logic                  above_hi,
   input  logic                  middle_lo,
   input  logic                  middle_hi,
   output logic                  above_bit,
   output logic                  middle_bit,
   output logic                  next_bit
);

   logic       above_ff, above_in;
   logic       middle_ff, middle_in;
   logic [2:0] below;
   logic [3:0] count;

   always_comb begin
      above_in  = above_ff;
      middle_in = middle_ff;
      if (ctl.clear) begin
         above_in  = 1'b0;
         middle_in = 1'b0;
      end else if (ctl.load) begin
         above_in  = ctl.first ? 1'b0 : middle_ff;
         middle_in = row_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
      end
   end

   always_comb begin
      below = ctl.use_row ? {row_hi, row_bit, row_lo} : 3'b000;
      count = 4'(above_lo) + 4'(above_ff) + 4'(above_hi)
            + 4'(middle_lo) + 4'(middle_hi)
            + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
      next_bit = col_en && ((count == lgre_pkg::BirthCount)
                 || (count == lgre_pkg::SurviveCount && middle_ff));
   end

   assign above_bit  = above_ff;
   assign middle_bit = middle_ff;

endmodule
